### hdl/spu_pkg.sv
// ----------------------------------------------------------------------------
// spu_pkg
// Types, codes and helpers shared by the sorted prefix set unit.
// ----------------------------------------------------------------------------
package spu_pkg;

  localparam int unsigned LEN_W  = 4;
  localparam int unsigned DATA_W = 64;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_QUERY  = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_PICK
  } spu_state_e;

  // fields of the latched item that every cell sees
  typedef struct packed {
    logic [LEN_W-1:0] len;
    logic             mk;
    logic [LEN_W-1:0] inv;
  } spu_bcast_t;

  // per-cell compare results, registered in the cell
  typedef struct packed {
    logic occ;   // cell holds a stored entry
    logic last;  // last stored entry
    logic lt;    // entry below the inserted pair
    logic dup;   // entry equals the inserted pair
    logic ge;    // entry bytes not below the prefix
    logic pre;   // entry starts with the prefix
    logic mis;   // entry breaks the invariant bytes
  } spu_flags_t;

  // top-aligned mask of the first len bytes, len at most eight
  function automatic logic [DATA_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
    logic [6:0] sh;
    sh = {len, 3'b000};
    return ~({DATA_W{1'b1}} >> sh);
  endfunction

endpackage

### hdl/spu_in_if.sv
// ----------------------------------------------------------------------------
// spu_in_if
// Input channel: one insert or query item per handshake.
// ----------------------------------------------------------------------------
interface spu_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [63:0] key_data;
  logic [3:0]  key_length;
  logic        marker_in;
  logic [3:0]  invariant_length;

  modport source (
    output valid, command, key_data, key_length, marker_in, invariant_length,
    input  ready
  );
  modport sink (
    input  valid, command, key_data, key_length, marker_in, invariant_length,
    output ready
  );
endinterface

### hdl/spu_out_if.sv
// ----------------------------------------------------------------------------
// spu_out_if
// Output channel: one result item per input item.
// ----------------------------------------------------------------------------
interface spu_out_if;
  logic        valid;
  logic        ready;
  logic        contained;
  logic        next_found;
  logic [63:0] next_key;
  logic [3:0]  next_length;
  logic        table_full;

  modport source (
    output valid, contained, next_found, next_key, next_length, table_full,
    input  ready
  );
  modport sink (
    input  valid, contained, next_found, next_key, next_length, table_full,
    output ready
  );
endinterface

### hdl/spu_cell.sv
// ----------------------------------------------------------------------------
// spu_cell
// One slot of the sorted row: holds an entry, compares it with the broadcast
// key and on insert shifts in its left neighbor's entry or takes the new key.
// ----------------------------------------------------------------------------
module spu_cell #(
  parameter int unsigned IDX   = 0,
  parameter int unsigned KEY_W = 64,
  parameter int unsigned CNT_W = 7
) (
  input  logic                    clk_i,
  input  logic                    flag_en_i,
  input  logic                    commit_i,
  input  spu_pkg::spu_bcast_t     bc_i,
  input  logic [KEY_W-1:0]        key_i,
  input  logic [KEY_W-1:0]        key_inv_i,
  input  logic [CNT_W-1:0]        count_i,
  input  logic                    prev_lt_i,
  input  logic [KEY_W-1:0]        prev_bytes_i,
  input  logic [spu_pkg::LEN_W-1:0] prev_len_i,
  input  logic                    prev_mk_i,
  output logic [KEY_W-1:0]        bytes_o,
  output logic [spu_pkg::LEN_W-1:0] len_o,
  output logic                    mk_o,
  output spu_pkg::spu_flags_t     flags_o
);

  logic [KEY_W-1:0]          bytes_q;
  logic [spu_pkg::LEN_W-1:0] len_q;
  logic                      mk_q;
  spu_pkg::spu_flags_t       flags_q, flags_d;

  logic [spu_pkg::DATA_W-1:0] mask_len64, mask_inv64;
  logic [KEY_W-1:0]           mask_len, mask_inv;
  logic                       b_lt, b_eq;

  assign mask_len64 = spu_pkg::byte_mask(bc_i.len);
  assign mask_inv64 = spu_pkg::byte_mask(bc_i.inv);
  assign mask_len   = mask_len64[spu_pkg::DATA_W-1 -: KEY_W];
  assign mask_inv   = mask_inv64[spu_pkg::DATA_W-1 -: KEY_W];

  // zero padding makes a plain value compare lexicographic, length breaks ties
  assign b_lt = (bytes_q < key_i) || ((bytes_q == key_i) && (len_q < bc_i.len));
  assign b_eq = (bytes_q == key_i) && (len_q == bc_i.len);

  always_comb begin
    flags_d.occ  = count_i > CNT_W'(IDX);
    flags_d.last = count_i == CNT_W'(IDX + 1);
    flags_d.lt   = flags_d.occ && (b_lt || (b_eq && !mk_q && bc_i.mk));
    flags_d.dup  = flags_d.occ && b_eq && (mk_q == bc_i.mk);
    flags_d.ge   = flags_d.occ && !b_lt;
    flags_d.pre  = flags_d.occ && (len_q >= bc_i.len) && ((bytes_q & mask_len) == key_i);
    flags_d.mis  = (bc_i.inv != '0) &&
                   !((len_q >= bc_i.inv) && ((bytes_q & mask_inv) == key_inv_i));
  end

  always_ff @(posedge clk_i) begin
    if (flag_en_i) begin
      flags_q <= flags_d;
    end
    if (commit_i && !flags_q.lt) begin
      if (prev_lt_i) begin
        bytes_q <= key_i;
        len_q   <= bc_i.len;
        mk_q    <= bc_i.mk;
      end else begin
        bytes_q <= prev_bytes_i;
        len_q   <= prev_len_i;
        mk_q    <= prev_mk_i;
      end
    end
  end

  assign bytes_o = bytes_q;
  assign len_o   = len_q;
  assign mk_o    = mk_q;
  assign flags_o = flags_q;

endmodule

### hdl/spu_pick.sv
// ----------------------------------------------------------------------------
// spu_pick
// Reduces the row's flags: duplicate and prefix hits, lower bound and the
// first marked entry of the scan.
// ----------------------------------------------------------------------------
module spu_pick #(
  parameter int unsigned N     = 64,
  parameter int unsigned KEY_W = 64
) (
  input  spu_pkg::spu_flags_t       flags_i [N],
  input  logic [KEY_W-1:0]          bytes_i [N],
  input  logic [spu_pkg::LEN_W-1:0] len_i   [N],
  input  logic                      mk_i    [N],
  output logic                      dup_o,
  output logic                      contained_o,
  output logic                      found_o,
  output logic [KEY_W-1:0]          bytes_o,
  output logic [spu_pkg::LEN_W-1:0] len_o
);

  logic [N-1:0] ge_v, last_v, stop_v, hit_v, dup_v, pre_v, cand, first;
  logic         none_ge;

  always_comb begin
    for (int i = 0; i < N; i++) begin
      ge_v[i]   = flags_i[i].ge;
      last_v[i] = flags_i[i].last;
      stop_v[i] = flags_i[i].occ && (flags_i[i].mis || mk_i[i]);
      hit_v[i]  = mk_i[i] && !flags_i[i].mis;
      dup_v[i]  = flags_i[i].dup;
      pre_v[i]  = flags_i[i].pre;
    end
  end

  assign none_ge = ~|ge_v;
  // sorted row: the ge cells form a suffix, so this masks lower bound onward
  assign cand  = (ge_v | (last_v & {N{none_ge}})) & stop_v;
  assign first = cand & (~cand + N'(1));

  assign dup_o       = |dup_v;
  assign contained_o = |pre_v;
  assign found_o     = |(first & hit_v);

  always_comb begin
    bytes_o = '0;
    len_o   = '0;
    for (int i = 0; i < N; i++) begin
      if (first[i] && hit_v[i]) begin
        bytes_o = bytes_o | bytes_i[i];
        len_o   = len_o | len_i[i];
      end
    end
  end

endmodule

### hdl/sorted_prefix_set_unit.sv
// ----------------------------------------------------------------------------
// sorted_prefix_set_unit
// Sorted, duplicate-free table of byte keys with marker bits, held in a row
// of cells; answers prefix queries and finds the next marked key.
// ----------------------------------------------------------------------------
//  channel  dir  modport  fields
//  in_i     in   sink     command key_data key_length marker_in invariant_length
//  out_o    out  source   contained next_found next_key next_length table_full
//
//  an item is accepted, then in the compare step every cell compares its entry
//  with the key and registers its flags; the pick step reduces the flags and
//  shifts the row, and the next item can be accepted during the pick step once
//  the output register is free, so items overlap
//  reset clears the state, entry count and output valid flag; no clearing pass
//  a result waiting in the output register holds the block in its pick step
// ----------------------------------------------------------------------------
module sorted_prefix_set_unit #(
  parameter int unsigned MAX_KEYS  = 64,
  parameter int unsigned KEY_BYTES = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  spu_in_if.sink    in_i,
  spu_out_if.source out_o
);

  localparam int unsigned KEY_W = 8 * KEY_BYTES;
  localparam int unsigned CNT_W = $clog2(MAX_KEYS + 1);
  localparam int unsigned LEN_W = spu_pkg::LEN_W;

  spu_pkg::spu_state_e state_q, state_d;
  logic [CNT_W-1:0]    count_q, count_d;

  logic                cmd_q;
  spu_pkg::spu_bcast_t bc_q;
  logic [KEY_W-1:0]    key_q, key_inv_q;

  logic in_acc, out_free, pick_go, commit, full;

  // input saturation and masking
  logic [LEN_W-1:0]           len_sat, inv_sat, inv_eff;
  logic [spu_pkg::DATA_W-1:0] mask_len64, mask_inv64, key_len64, key_inv64;

  assign len_sat = (in_i.key_length > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES)
                                                         : in_i.key_length;
  assign inv_sat = (in_i.invariant_length > LEN_W'(KEY_BYTES)) ? LEN_W'(KEY_BYTES)
                                                               : in_i.invariant_length;
  assign inv_eff    = (inv_sat > len_sat) ? len_sat : inv_sat;
  assign mask_len64 = spu_pkg::byte_mask(len_sat);
  assign mask_inv64 = spu_pkg::byte_mask(inv_eff);
  assign key_len64  = in_i.key_data & mask_len64;
  assign key_inv64  = in_i.key_data & mask_inv64;

  // row of cells
  spu_pkg::spu_flags_t flags [MAX_KEYS];
  logic [KEY_W-1:0]    bytes [MAX_KEYS];
  logic [LEN_W-1:0]    lens  [MAX_KEYS];
  logic                mks   [MAX_KEYS];

  for (genvar g = 0; g < MAX_KEYS; g++) begin : g_cell
    logic             prev_lt;
    logic [KEY_W-1:0] prev_bytes;
    logic [LEN_W-1:0] prev_len;
    logic             prev_mk;

    if (g == 0) begin : g_head
      assign prev_lt    = 1'b1;
      assign prev_bytes = key_q;
      assign prev_len   = bc_q.len;
      assign prev_mk    = bc_q.mk;
    end else begin : g_body
      assign prev_lt    = flags[g-1].lt;
      assign prev_bytes = bytes[g-1];
      assign prev_len   = lens[g-1];
      assign prev_mk    = mks[g-1];
    end

    spu_cell #(
      .IDX   (g),
      .KEY_W (KEY_W),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i        (clk_i),
      .flag_en_i    (state_q == spu_pkg::ST_CMP),
      .commit_i     (commit),
      .bc_i         (bc_q),
      .key_i        (key_q),
      .key_inv_i    (key_inv_q),
      .count_i      (count_q),
      .prev_lt_i    (prev_lt),
      .prev_bytes_i (prev_bytes),
      .prev_len_i   (prev_len),
      .prev_mk_i    (prev_mk),
      .bytes_o      (bytes[g]),
      .len_o        (lens[g]),
      .mk_o         (mks[g]),
      .flags_o      (flags[g])
    );
  end

  logic             dup, contained, found;
  logic [KEY_W-1:0] sel_bytes;
  logic [LEN_W-1:0] sel_len;

  spu_pick #(
    .N     (MAX_KEYS),
    .KEY_W (KEY_W)
  ) u_pick (
    .flags_i     (flags),
    .bytes_i     (bytes),
    .len_i       (lens),
    .mk_i        (mks),
    .dup_o       (dup),
    .contained_o (contained),
    .found_o     (found),
    .bytes_o     (sel_bytes),
    .len_o       (sel_len)
  );

  // control
  logic out_valid_q;

  assign out_free = !out_valid_q || out_o.ready;
  assign pick_go  = (state_q == spu_pkg::ST_PICK) && out_free;
  assign full     = count_q == CNT_W'(MAX_KEYS);
  assign commit   = pick_go && (cmd_q == spu_pkg::CMD_INSERT) && !dup && !full;

  assign in_i.ready = (state_q == spu_pkg::ST_IDLE) || pick_go;
  assign in_acc     = in_i.valid && in_i.ready;

  always_comb begin
    state_d = state_q;
    count_d = count_q;
    unique case (state_q)
      spu_pkg::ST_IDLE: begin
        if (in_acc) state_d = spu_pkg::ST_CMP;
      end
      spu_pkg::ST_CMP: begin
        state_d = spu_pkg::ST_PICK;
      end
      spu_pkg::ST_PICK: begin
        if (pick_go) begin
          state_d = in_acc ? spu_pkg::ST_CMP : spu_pkg::ST_IDLE;
          if (commit) count_d = count_q + CNT_W'(1);
        end
      end
      default: state_d = spu_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= spu_pkg::ST_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // latched item
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      cmd_q     <= in_i.command;
      bc_q.len  <= len_sat;
      bc_q.mk   <= in_i.marker_in;
      bc_q.inv  <= inv_eff;
      key_q     <= key_len64[spu_pkg::DATA_W-1 -: KEY_W];
      key_inv_q <= key_inv64[spu_pkg::DATA_W-1 -: KEY_W];
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (pick_go) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  logic                       is_query;
  logic [spu_pkg::DATA_W-1:0] sel_key64;

  assign is_query  = cmd_q == spu_pkg::CMD_QUERY;
  assign sel_key64 = spu_pkg::DATA_W'(sel_bytes) << (spu_pkg::DATA_W - KEY_W);

  always_ff @(posedge clk_i) begin
    if (pick_go) begin
      out_o.contained   <= is_query && contained;
      out_o.next_found  <= is_query && found;
      out_o.next_key    <= is_query ? sel_key64 : '0;
      out_o.next_length <= is_query ? sel_len : '0;
      out_o.table_full  <= !is_query && !dup && full;
    end
  end

  assign out_o.valid = out_valid_q;

  // checks
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CNT_W'(MAX_KEYS))
    else $error("entry count beyond table size");

  a_full_no_query: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.table_full |-> !out_o.contained && !out_o.next_found)
    else $error("table full flag on a query result");

  a_none_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && !out_o.next_found |-> out_o.next_key == '0 && out_o.next_length == '0)
    else $error("next key data without a found key");

  a_commit_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    commit |=> count_q == $past(count_q) + CNT_W'(1))
    else $error("insert did not grow the table");

  a_accept_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == spu_pkg::ST_CMP)
    else $error("accepted item skipped the compare step");

endmodule

### tb/sv/tb_sorted_prefix_set_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_prefix_set_unit
// Sends insert and query items through the sorted prefix set unit, with
// random gaps on the input and random stalls on the output. A scoreboard
// keeps its own sorted key table, works out the answer to each accepted
// item and checks every returned answer, field by field, in order.
// ----------------------------------------------------------------------------
module tb_sorted_prefix_set_unit;

  localparam int unsigned TABLE_DEPTH  = 64;
  localparam int unsigned KEY_MAX      = 8;
  localparam int unsigned RANDOM_ITEMS = 580;
  localparam int unsigned HOLD_AT      = 200;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned CYCLE_LIMIT  = 200000;

  typedef struct packed {
    logic        command;
    logic [63:0] key_data;
    logic [3:0]  key_length;
    logic        marker_in;
    logic [3:0]  invariant_length;
  } spu_item_t;

  typedef struct packed {
    logic        contained;
    logic        next_found;
    logic [63:0] next_key;
    logic [3:0]  next_length;
    logic        table_full;
  } spu_answer_t;

  class key_table_scoreboard;
    logic [63:0]  tbl_bytes [TABLE_DEPTH];
    logic [3:0]   tbl_len [TABLE_DEPTH];
    bit           tbl_mark [TABLE_DEPTH];
    int unsigned  tbl_count;
    spu_answer_t  pending_answers [$];
    int unsigned  errors;

    function new();
      tbl_count = 0;
      errors    = 0;
    endfunction

    // top-aligned mask of the first n bytes
    static function logic [63:0] lead_mask(int unsigned n);
      return ~(64'hFFFF_FFFF_FFFF_FFFF >> (8 * n));
    endfunction

    // lexicographic order, a proper prefix first
    function int key_order(logic [63:0] a, int unsigned la, logic [63:0] b, int unsigned lb);
      int unsigned m;
      logic [63:0] am, bm;
      m  = (la < lb) ? la : lb;
      am = a & lead_mask(m);
      bm = b & lead_mask(m);
      if (am != bm) return (am < bm) ? -1 : 1;
      if (la == lb) return 0;
      return (la < lb) ? -1 : 1;
    endfunction

    function bit has_lead(logic [63:0] k, int unsigned lk, logic [63:0] p, int unsigned lp);
      return (lk >= lp) && (((k ^ p) & lead_mask(lp)) == 64'd0);
    endfunction

    function spu_answer_t table_answer(spu_item_t it);
      spu_answer_t ans;
      int unsigned len, inv, pos, i;
      logic [63:0] key;
      int c;
      len = (it.key_length > KEY_MAX) ? KEY_MAX : it.key_length;
      inv = (it.invariant_length > KEY_MAX) ? KEY_MAX : it.invariant_length;
      key = it.key_data & lead_mask(len);
      ans = '0;
      if (it.command == spu_pkg::CMD_INSERT) begin
        pos = 0;
        c   = 1;
        while (pos < tbl_count) begin
          c = key_order(tbl_bytes[pos], tbl_len[pos], key, len);
          if (c == 0) c = int'(tbl_mark[pos]) - int'(it.marker_in);
          if (c >= 0) break;
          pos++;
        end
        if (pos < tbl_count && c == 0) return ans;
        if (tbl_count >= TABLE_DEPTH) begin
          ans.table_full = 1'b1;
          return ans;
        end
        for (i = tbl_count; i > pos; i--) begin
          tbl_bytes[i] = tbl_bytes[i-1];
          tbl_len[i]   = tbl_len[i-1];
          tbl_mark[i]  = tbl_mark[i-1];
        end
        tbl_bytes[pos] = key;
        tbl_len[pos]   = 4'(len);
        tbl_mark[pos]  = it.marker_in;
        tbl_count++;
        return ans;
      end
      if (tbl_count == 0) return ans;
      for (i = 0; i < tbl_count; i++)
        if (has_lead(tbl_bytes[i], tbl_len[i], key, len)) ans.contained = 1'b1;
      pos = 0;
      while (pos < tbl_count && key_order(tbl_bytes[pos], tbl_len[pos], key, len) < 0) pos++;
      // every key below the prefix: scan from the last entry
      if (pos >= tbl_count) pos = tbl_count - 1;
      if (inv > len) inv = len;
      for (i = pos; i < tbl_count; i++) begin
        if (inv != 0 && !has_lead(tbl_bytes[i], tbl_len[i], key, inv)) break;
        if (tbl_mark[i]) begin
          ans.next_found  = 1'b1;
          ans.next_key    = tbl_bytes[i];
          ans.next_length = tbl_len[i];
          break;
        end
      end
      return ans;
    endfunction

    function void note_item(spu_item_t it);
      pending_answers.push_back(table_answer(it));
    endfunction

    function int unsigned pending();
      return pending_answers.size();
    endfunction

    function void compare_field(string name, logic [63:0] want, logic [63:0] got);
      if (got !== want) begin
        $error("%s: expected %0h, got %0h", name, want, got);
        errors++;
      end
    endfunction

    function void check_result(spu_answer_t got);
      spu_answer_t want;
      if (pending_answers.size() == 0) begin
        $error("answer with no item waiting: %0h", got);
        errors++;
        return;
      end
      want = pending_answers.pop_front();
      compare_field("contained", 64'(want.contained), 64'(got.contained));
      compare_field("next_found", 64'(want.next_found), 64'(got.next_found));
      compare_field("next_key", want.next_key, got.next_key);
      compare_field("next_length", 64'(want.next_length), 64'(got.next_length));
      compare_field("table_full", 64'(want.table_full), 64'(got.table_full));
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;

  spu_in_if  in_if ();
  spu_out_if out_if ();

  sorted_prefix_set_unit #(
    .MAX_KEYS  (TABLE_DEPTH),
    .KEY_BYTES (KEY_MAX)
  ) u_top (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if.sink),
    .out_o  (out_if.source)
  );

  always #10 clk_i = ~clk_i;

  key_table_scoreboard key_sb = new();

  logic [63:0] known_keys [$];
  int unsigned known_lens [$];
  bit          tx_burst = 1'b0;
  bit          rx_burst = 1'b0;
  int unsigned results_seen = 0;
  int unsigned cycle_count = 0;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[sorted_prefix_set_unit] ERROR");
      $finish;
    end
  end

  function automatic spu_item_t make_item(logic cmd, logic [63:0] data, logic [3:0] len,
                                          logic mk, logic [3:0] inv);
    spu_item_t it;
    it.command          = cmd;
    it.key_data         = data;
    it.key_length       = len;
    it.marker_in        = mk;
    it.invariant_length = inv;
    return it;
  endfunction

  // small alphabet so keys share prefixes and repeat
  function automatic logic [7:0] pick_byte();
    case ($urandom_range(0, 9))
      0, 1:    return 8'h00;
      2, 3, 4: return 8'h41;
      5, 6:    return 8'h42;
      7, 8:    return 8'hFF;
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic spu_item_t random_insert();
    spu_item_t it;
    int unsigned n;
    it.command    = spu_pkg::CMD_INSERT;
    it.key_length = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(9, 15))
                                                : 4'($urandom_range(0, 8));
    n = (it.key_length > KEY_MAX) ? KEY_MAX : it.key_length;
    if ($urandom_range(0, 7) == 0) begin
      it.key_data = {$urandom, $urandom};
    end else begin
      for (int i = 0; i < 8; i++) it.key_data[63-8*i -: 8] = pick_byte();
      if ($urandom_range(0, 3) != 0) it.key_data &= key_table_scoreboard::lead_mask(n);
    end
    it.marker_in        = 1'($urandom_range(0, 1));
    it.invariant_length = 4'($urandom_range(0, 15));
    return it;
  endfunction

  // mostly prefixes of keys already sent, sometimes with the last byte changed
  function automatic spu_item_t random_query();
    spu_item_t it;
    int unsigned idx, n;
    logic [63:0] m;
    it.command   = spu_pkg::CMD_QUERY;
    it.marker_in = 1'($urandom_range(0, 1));
    if (known_keys.size() != 0 && $urandom_range(0, 9) < 7) begin
      idx = $urandom_range(0, known_keys.size() - 1);
      n   = $urandom_range(0, known_lens[idx]);
      it.key_data = known_keys[idx];
      if (n != 0 && $urandom_range(0, 3) == 0) it.key_data[63-8*(n-1) -: 8] = pick_byte();
    end else begin
      n = $urandom_range(0, 8);
      it.key_data = {$urandom, $urandom};
    end
    m = key_table_scoreboard::lead_mask(n);
    if ($urandom_range(0, 3) != 0) it.key_data &= m;
    else it.key_data = (it.key_data & m) | ({$urandom, $urandom} & ~m);
    it.key_length = (n == 8 && $urandom_range(0, 3) == 0) ? 4'($urandom_range(8, 15)) : 4'(n);
    it.invariant_length = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(0, 15))
                                                      : 4'($urandom_range(0, n));
    return it;
  endfunction

  task automatic offer_item(input spu_item_t it);
    int unsigned gap, n;
    if (it.command == spu_pkg::CMD_INSERT) begin
      n = (it.key_length > KEY_MAX) ? KEY_MAX : it.key_length;
      known_keys.push_back(it.key_data & key_table_scoreboard::lead_mask(n));
      known_lens.push_back(n);
    end
    if ($urandom_range(0, 19) == 0) tx_burst = !tx_burst;
    gap = tx_burst ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid            <= 1'b1;
    in_if.command          <= it.command;
    in_if.key_data         <= it.key_data;
    in_if.key_length       <= it.key_length;
    in_if.marker_in        <= it.marker_in;
    in_if.invariant_length <= it.invariant_length;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    key_sb.note_item(it);
  endtask

  initial begin
    rst_ni                 <= 1'b0;
    in_if.valid            <= 1'b0;
    in_if.command          <= spu_pkg::CMD_INSERT;
    in_if.key_data         <= '0;
    in_if.key_length       <= '0;
    in_if.marker_in        <= 1'b0;
    in_if.invariant_length <= '0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table
    offer_item(make_item(spu_pkg::CMD_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0, 4'd8));
    // empty key with both markers, bytes past the length ignored, duplicate
    offer_item(make_item(spu_pkg::CMD_INSERT, 64'h0, 4'd0, 1'b0, 4'd0));
    offer_item(make_item(spu_pkg::CMD_INSERT, 64'h1234_5678_9ABC_DEF0, 4'd0, 1'b1, 4'd0));
    offer_item(make_item(spu_pkg::CMD_INSERT, 64'h0, 4'd0, 1'b1, 4'd0));
    offer_item(make_item(spu_pkg::CMD_INSERT, 64'h4142_0000_0000_0000, 4'd2, 1'b0, 4'd0));
    offer_item(make_item(spu_pkg::CMD_INSERT, 64'h4142_43FF_FFFF_FFFF, 4'd3, 1'b1, 4'd15));
    offer_item(make_item(spu_pkg::CMD_INSERT, 64'h4142_4344_4500_0000, 4'd5, 1'b1, 4'd0));
    offer_item(make_item(spu_pkg::CMD_INSERT, 64'h4200_0000_0000_0000, 4'd1, 1'b1, 4'd0));
    // prefix above every key
    offer_item(make_item(spu_pkg::CMD_QUERY, 64'hFF00_0000_0000_0000, 4'd1, 1'b0, 4'd1));
    offer_item(make_item(spu_pkg::CMD_QUERY, 64'hFF00_0000_0000_0000, 4'd1, 1'b1, 4'd0));
    offer_item(make_item(spu_pkg::CMD_QUERY, 64'h4100_0000_0000_0000, 4'd1, 1'b0, 4'd0));
    offer_item(make_item(spu_pkg::CMD_QUERY, 64'h4142_0000_0000_0000, 4'd2, 1'b0, 4'd2));
    offer_item(make_item(spu_pkg::CMD_QUERY, 64'h4142_0000_0000_0000, 4'd2, 1'b0, 4'd15));
    // lower bound is a key shorter than the invariant bytes
    offer_item(make_item(spu_pkg::CMD_QUERY, 64'h4150_0000_0000_0000, 4'd2, 1'b0, 4'd2));
    offer_item(make_item(spu_pkg::CMD_QUERY, 64'h4150_0000_0000_0000, 4'd2, 1'b0, 4'd0));
    offer_item(make_item(spu_pkg::CMD_QUERY, 64'h0, 4'd0, 1'b0, 4'd0));
    offer_item(make_item(spu_pkg::CMD_QUERY, 64'h4142_43AA_AAAA_AAAA, 4'd3, 1'b1, 4'd3));
    offer_item(make_item(spu_pkg::CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b1, 4'd0));
    offer_item(make_item(spu_pkg::CMD_INSERT, 64'hFFFF_FFFF_FFFF_FFFF, 4'd15, 1'b0, 4'd0));
    offer_item(make_item(spu_pkg::CMD_INSERT, {$urandom, $urandom}, 4'd12, 1'b1, 4'd0));
    offer_item(make_item(spu_pkg::CMD_QUERY, 64'hFFFF_FFFF_FFFF_FFFF, 4'd8, 1'b0, 4'd8));
    offer_item(make_item(spu_pkg::CMD_QUERY, 64'h4100_0000_0000_0000, 4'd1, 1'b0, 4'd9));
    offer_item(make_item(spu_pkg::CMD_QUERY, 64'h4100_0000_0000_0000, 4'd13, 1'b0, 4'd0));

    // few inserts first so queries see a partly filled table, then fill it up
    for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
      if ($urandom_range(0, 99) < ((n < RANDOM_ITEMS / 2) ? 15 : 40))
        offer_item(random_insert());
      else
        offer_item(random_query());
    end
    in_if.valid <= 1'b0;

    while (key_sb.pending() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (key_sb.errors == 0) begin
      $display("[sorted_prefix_set_unit] OK");
    end else begin
      $display("[sorted_prefix_set_unit] ERROR");
    end
    $finish;
  end

  initial begin
    spu_answer_t got;
    int unsigned hold;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      // one long hold-off so the block fills and stalls its input
      if (results_seen == HOLD_AT) begin
        hold = HOLD_CYCLES;
      end else begin
        if ($urandom_range(0, 19) == 0) rx_burst = !rx_burst;
        hold = rx_burst ? 0 : $urandom_range(0, 7);
      end
      if (hold != 0) begin
        out_if.ready <= 1'b0;
        repeat (hold) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
      got.contained   = out_if.contained;
      got.next_found  = out_if.next_found;
      got.next_key    = out_if.next_key;
      got.next_length = out_if.next_length;
      got.table_full  = out_if.table_full;
      key_sb.check_result(got);
      results_seen++;
    end
  end

endmodule
